FILE: src/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds shared constants, the controller state type and the digit cell control types.
// No dependencies.
`timescale 1ns / 1ps

package b2da_pkg;

  // Width of the binary input value and of the pad count.
  localparam int unsigned ValueW = 32;
  localparam int unsigned PadW = 4;

  // One BCD digit per cell.
  localparam int unsigned DigitW = 4;

  // Output character width and the code of the character zero.
  localparam int unsigned CharW = 6;
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // Default length of the digit chain, which is also the character limit.
  localparam int unsigned MaxDigitsDef = 10;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StScan,
    StSkip,
    StEmit
  } b2da_state_e;

  // Operation that every cell of the chain performs.
  typedef enum logic [1:0] {
    OpHold,
    OpClear,
    OpShiftBit,
    OpShiftDigit
  } b2da_cell_op_e;

  // Control word for the whole chain.
  typedef struct packed {
    b2da_cell_op_e op;
    logic          rotate;
  } b2da_chain_ctrl_t;

endpackage

FILE: src/b2da_cell.sv
// One BCD digit cell of the double dabble chain.
// Depends on b2da_pkg for the cell operation codes.
`timescale 1ns / 1ps

module b2da_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b2da_pkg::b2da_cell_op_e      op_i,
  input  logic                         bit_i,
  input  logic [b2da_pkg::DigitW-1:0]  digit_i,
  output logic                         carry_o,
  output logic [b2da_pkg::DigitW-1:0]  digit_o
);
  import b2da_pkg::*;

  logic [DigitW-1:0] digit_q;
  logic [DigitW-1:0] digit_d;
  logic [DigitW-1:0] adj;

  // Add three to digits of five or more so that the next doubling carries correctly.
  assign adj = (digit_q >= DigitW'(5)) ? (digit_q + DigitW'(3)) : digit_q;

  // The top bit of the adjusted digit moves into the next cell up.
  assign carry_o = adj[DigitW-1];
  assign digit_o = digit_q;

  // Next digit value for each operation.
  always_comb begin
    case (op_i)
      OpHold:       digit_d = digit_q;
      OpClear:      digit_d = '0;
      OpShiftBit:   digit_d = {adj[DigitW-2:0], bit_i};
      OpShiftDigit: digit_d = digit_i;
      default:      digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

FILE: src/b2da_chain.sv
// Row of BCD digit cells, least significant cell first.
// Shifts binary bits in during conversion and whole digits toward the top afterwards.
// Depends on b2da_pkg and b2da_cell.
`timescale 1ns / 1ps

module b2da_chain #(
  parameter int unsigned MaxDigits = b2da_pkg::MaxDigitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b2da_pkg::b2da_chain_ctrl_t   ctrl_i,
  input  logic                         bit_i,
  output logic [b2da_pkg::DigitW-1:0]  top_digit_o,
  output logic                         carry_o
);
  import b2da_pkg::*;

  logic [MaxDigits:0]   carry;
  logic [DigitW-1:0]    digit [MaxDigits];
  logic [DigitW-1:0]    digit_in [MaxDigits];

  // The lowest cell takes the new binary bit.
  assign carry[0] = bit_i;

  // During a rotation the top digit wraps around to the bottom cell.
  assign digit_in[0] = ctrl_i.rotate ? digit[MaxDigits-1] : '0;

  for (genvar k = 0; k < MaxDigits; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign digit_in[k] = digit[k-1];
    end

    b2da_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (ctrl_i.op),
      .bit_i   (carry[k]),
      .digit_i (digit_in[k]),
      .carry_o (carry[k+1]),
      .digit_o (digit[k])
    );
  end

  assign top_digit_o = digit[MaxDigits-1];
  assign carry_o     = carry[MaxDigits];

endmodule

FILE: src/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg and b2da_chain.
//
//   Channel | Signals                               | Direction
//   input   | in_valid_i, in_ready_o, value_i,      | into the block
//           | pad_zeros_i                           |
//   output  | out_valid_o, out_ready_i,             | out of the block
//           | char_code_o, last_char_o              |
//
// One word runs double dabble in the digit chain over every bit of the value, then a
// rotation through all MaxDigits cells to find the leading zeros, then a skip step that
// drops the unwanted leading digits, and then the characters one by one. Dropped digits and
// characters add up to MaxDigits. The block handles one word at a time: it takes no new
// word until the last character of the current one sits in the output register.
// Reset clears the controller and the output valid; the digit cells come out as zero.
// A stalled output holds its character and stops the emission until it is taken.
// in_ready_o rises as soon as the last character sits in the output register.
`timescale 1ns / 1ps

module binary_to_decimal_ascii #(
  parameter int unsigned MaxDigits = b2da_pkg::MaxDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [b2da_pkg::ValueW-1:0]   value_i,
  input  logic [b2da_pkg::PadW-1:0]     pad_zeros_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b2da_pkg::CharW-1:0]    char_code_o,
  output logic                          last_char_o
);
  import b2da_pkg::*;

  localparam int unsigned CntW    = $clog2(MaxDigits + 1);
  localparam int unsigned SumW    = ((CntW > PadW) ? CntW : PadW) + 1;
  localparam int unsigned BitCntW = $clog2(ValueW);
  localparam logic [CntW-1:0]    NumCells = CntW'(MaxDigits);
  localparam logic [BitCntW-1:0] LastBit  = BitCntW'(ValueW - 1);

  b2da_state_e        state_q, state_d;
  logic [ValueW-1:0]  value_q, value_d;
  logic [PadW-1:0]    pad_q, pad_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic [CntW-1:0]    zeros_q, zeros_d;
  logic               seen_q, seen_d;
  logic               ovf_q, ovf_d;
  logic [CntW-1:0]    skip_q, skip_d;
  logic [CntW-1:0]    left_q, left_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;

  b2da_chain_ctrl_t   chain_ctrl;
  logic [DigitW-1:0]  top_digit;
  logic               top_carry;

  logic               accept;
  logic               out_free;
  logic               zero_hit;
  logic [CntW-1:0]    zeros_nx;
  logic [CntW-1:0]    sig_cnt;
  logic [SumW-1:0]    total_sum;
  logic [CntW-1:0]    total;

  b2da_chain #(
    .MaxDigits (MaxDigits)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (chain_ctrl),
    .bit_i       (value_q[ValueW-1]),
    .top_digit_o (top_digit),
    .carry_o     (top_carry)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Character count from the leading zero scan, the overflow flag and the pad request.
  assign zero_hit  = !seen_q && (top_digit == '0);
  assign zeros_nx  = zeros_q + CntW'(zero_hit);
  assign sig_cnt   = ovf_q ? NumCells :
                     ((zeros_nx == NumCells) ? CntW'(1) : (NumCells - zeros_nx));
  assign total_sum = SumW'(sig_cnt) + SumW'(pad_q);
  assign total     = (total_sum > SumW'(MaxDigits)) ? NumCells : total_sum[CntW-1:0];

  // Next state, chain control and output register loading.
  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    pad_d       = pad_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    zeros_d     = zeros_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    skip_d      = skip_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    chain_ctrl  = '{op: OpHold, rotate: 1'b0};
    in_ready_o  = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (accept) begin
          chain_ctrl.op = OpClear;
          value_d       = value_i;
          pad_d         = pad_zeros_i;
          bit_cnt_d     = '0;
          ovf_d         = 1'b0;
          state_d       = StConv;
        end
      end

      StConv: begin
        chain_ctrl.op = OpShiftBit;
        value_d       = {value_q[ValueW-2:0], 1'b0};
        bit_cnt_d     = bit_cnt_q + BitCntW'(1);
        ovf_d         = ovf_q || top_carry;
        if (bit_cnt_q == LastBit) begin
          dig_cnt_d = '0;
          zeros_d   = '0;
          seen_d    = 1'b0;
          state_d   = StScan;
        end
      end

      StScan: begin
        chain_ctrl = '{op: OpShiftDigit, rotate: 1'b1};
        dig_cnt_d  = dig_cnt_q + CntW'(1);
        zeros_d    = zeros_nx;
        seen_d     = !zero_hit;
        if (dig_cnt_q == NumCells - CntW'(1)) begin
          skip_d  = NumCells - total;
          left_d  = total;
          state_d = StSkip;
        end
      end

      StSkip: begin
        if (skip_q != '0) begin
          chain_ctrl.op = OpShiftDigit;
          skip_d        = skip_q - CntW'(1);
        end else begin
          state_d = StEmit;
        end
      end

      StEmit: begin
        if (out_free) begin
          chain_ctrl.op = OpShiftDigit;
          out_valid_d   = 1'b1;
          char_d        = AsciiZero + CharW'(top_digit);
          last_d        = (left_q == CntW'(1));
          left_d        = left_q - CntW'(1);
          if (left_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      zeros_q     <= '0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      skip_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      zeros_q     <= zeros_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      skip_q      <= skip_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pad_q   <= pad_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

FILE: src/b2da_checker.sv
// Port checker for the binary to decimal ASCII converter, bound to the top level.
// Depends on b2da_pkg for the field widths and the code of the character zero.
`timescale 1ns / 1ps

module b2da_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [b2da_pkg::ValueW-1:0]   value_i,
  input logic [b2da_pkg::PadW-1:0]     pad_zeros_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [b2da_pkg::CharW-1:0]    char_code_o,
  input logic                          last_char_o
);
  import b2da_pkg::*;

  // A new word is not taken in the cycle right after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accepted word");

  // Every character is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((char_code_o >= AsciiZero) && (char_code_o <= AsciiZero + CharW'(9))))
    else $error("character outside the decimal digits");

  // While characters of a word are still to come, no new word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_char_o) |-> !in_ready_o)
    else $error("input ready in the middle of a number");

  // A stalled character holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(char_code_o) && $stable(last_char_o)))
    else $error("stalled output word changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
